// ===== rtl/lsas_pkg.sv =====
// Shared constants, opcode codes and result type of the load/store address sequencer.
`default_nettype none
package lsas_pkg;

  localparam int unsigned REG_COUNT = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned REG_W     = 5;
  localparam int unsigned SIZE_W    = 2;

  // Register count widened by one bit so that it can be compared with index plus one.
  localparam logic [REG_W:0] REG_LIMIT = (REG_W + 1)'(REG_COUNT);

  // Primary opcodes.
  localparam logic [5:0] OP_XFORM = 6'd31;
  localparam logic [5:0] OP_LWZ   = 6'd32;
  localparam logic [5:0] OP_LBZ   = 6'd34;
  localparam logic [5:0] OP_STW   = 6'd36;
  localparam logic [5:0] OP_STB   = 6'd38;
  localparam logic [5:0] OP_LHZ   = 6'd40;
  localparam logic [5:0] OP_LHA   = 6'd42;
  localparam logic [5:0] OP_STH   = 6'd44;
  localparam logic [5:0] OP_LMW   = 6'd46;
  localparam logic [5:0] OP_STMW  = 6'd47;

  // Extended opcodes of the X-form group, with the update bit cleared.
  localparam logic [9:0] XO_LWZX  = 10'd23;
  localparam logic [9:0] XO_LBZX  = 10'd87;
  localparam logic [9:0] XO_STWX  = 10'd151;
  localparam logic [9:0] XO_STBX  = 10'd215;
  localparam logic [9:0] XO_LHZX  = 10'd279;
  localparam logic [9:0] XO_STHX  = 10'd407;
  localparam logic [9:0] XO_LHAX  = 10'd343;

  // Access sizes.
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

  typedef struct packed {
    logic              valid_access;
    logic              is_store;
    logic [SIZE_W-1:0] size_code;
    logic              sign_extend;
    logic [WORD_W-1:0] eff_address;
    logic [REG_W-1:0]  data_reg;
    logic              update_ra;
    logic [REG_W-1:0]  update_reg;
    logic              last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_single;
    logic start_seq;
    logic emit_seq;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_multi;
    logic seq_fin;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/lsas_if.sv =====
// Request and result channel interfaces of the load/store address sequencer.
`default_nettype none
interface lsas_req_if;
  logic                         valid;
  logic                         ready;
  logic [lsas_pkg::WORD_W-1:0]  instr_word;
  logic [lsas_pkg::WORD_W-1:0]  ra_value;
  logic [lsas_pkg::WORD_W-1:0]  rb_value;

  modport source (output valid, output instr_word, output ra_value, output rb_value,
                  input ready);
  modport sink (input valid, input instr_word, input ra_value, input rb_value,
                output ready);
endinterface

interface lsas_resp_if;
  logic                         valid;
  logic                         ready;
  logic                         valid_access;
  logic                         is_store;
  logic [lsas_pkg::SIZE_W-1:0]  size_code;
  logic                         sign_extend;
  logic [lsas_pkg::WORD_W-1:0]  eff_address;
  logic [lsas_pkg::REG_W-1:0]   data_reg;
  logic                         update_ra;
  logic [lsas_pkg::REG_W-1:0]   update_reg;
  logic                         last;

  modport source (output valid, output valid_access, output is_store, output size_code,
                  output sign_extend, output eff_address, output data_reg,
                  output update_ra, output update_reg, output last, input ready);
  modport sink (input valid, input valid_access, input is_store, input size_code,
                input sign_extend, input eff_address, input data_reg,
                input update_ra, input update_reg, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/lsas_dp.sv =====
// Datapath: instruction decode, address adder, multiple-word sequencer and result register.
`default_nettype none
module lsas_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lsas_pkg::WORD_W-1:0] instr_word,
  input  wire logic [lsas_pkg::WORD_W-1:0] ra_value,
  input  wire logic [lsas_pkg::WORD_W-1:0] rb_value,
  input  wire lsas_pkg::cmd_t              cmd,
  output lsas_pkg::status_t                sts,
  output lsas_pkg::result_t                res
);

  logic [5:0]                  op;
  logic [lsas_pkg::REG_W-1:0]  rd;
  logic [lsas_pkg::REG_W-1:0]  ra;
  logic [9:0]                  xo;
  logic [9:0]                  xo_kind;
  logic [5:0]                  op_pair;
  logic [lsas_pkg::WORD_W-1:0] base;
  logic [lsas_pkg::WORD_W-1:0] dext;
  logic [lsas_pkg::WORD_W-1:0] ea;
  logic                        ok;
  logic                        st;
  logic [lsas_pkg::SIZE_W-1:0] size;
  logic                        sx;
  logic                        upd;
  logic                        rd_in_range;
  lsas_pkg::result_t           dec;
  lsas_pkg::result_t           seq_res;

  logic [lsas_pkg::WORD_W-1:0] seq_address;
  logic [lsas_pkg::REG_W-1:0]  seq_reg_index;
  logic                        seq_is_store;

  assign op      = instr_word[31:26];
  assign rd      = instr_word[25:21];
  assign ra      = instr_word[20:16];
  assign xo      = instr_word[10:1];
  assign xo_kind = {xo[9:6], 1'b0, xo[4:0]};
  assign op_pair = {op[5:1], 1'b0};
  assign base    = (ra != '0) ? ra_value : '0;
  assign dext    = {{16{instr_word[15]}}, instr_word[15:0]};
  assign ea      = base + ((op == lsas_pkg::OP_XFORM) ? rb_value : dext);

  assign rd_in_range  = ({1'b0, rd} < lsas_pkg::REG_LIMIT);
  assign sts.is_multi = ((op == lsas_pkg::OP_LMW) || (op == lsas_pkg::OP_STMW)) && rd_in_range;
  assign sts.seq_fin  = (({1'b0, seq_reg_index} + 6'd1) >= lsas_pkg::REG_LIMIT);

  // Single-access decode; anything unrecognized falls out with ok low.
  always_comb begin
    ok   = 1'b1;
    st   = 1'b0;
    size = lsas_pkg::SIZE_BYTE;
    sx   = 1'b0;
    upd  = 1'b0;
    if (op == lsas_pkg::OP_XFORM) begin
      upd = xo[5];
      case (xo_kind)
        lsas_pkg::XO_LWZX: size = lsas_pkg::SIZE_WORD;
        lsas_pkg::XO_LHZX: size = lsas_pkg::SIZE_HALF;
        lsas_pkg::XO_LBZX: size = lsas_pkg::SIZE_BYTE;
        lsas_pkg::XO_STWX: begin st = 1'b1; size = lsas_pkg::SIZE_WORD; end
        lsas_pkg::XO_STHX: begin st = 1'b1; size = lsas_pkg::SIZE_HALF; end
        lsas_pkg::XO_STBX: begin st = 1'b1; size = lsas_pkg::SIZE_BYTE; end
        default: begin
          // The halfword algebraic load has no update variant here.
          if (xo == lsas_pkg::XO_LHAX) begin
            size = lsas_pkg::SIZE_HALF;
            sx   = 1'b1;
            upd  = 1'b0;
          end else begin
            ok = 1'b0;
          end
        end
      endcase
    end else begin
      upd = op[0];
      case (op_pair)
        lsas_pkg::OP_LWZ: size = lsas_pkg::SIZE_WORD;
        lsas_pkg::OP_LHZ: size = lsas_pkg::SIZE_HALF;
        lsas_pkg::OP_LBZ: size = lsas_pkg::SIZE_BYTE;
        lsas_pkg::OP_STW: begin st = 1'b1; size = lsas_pkg::SIZE_WORD; end
        lsas_pkg::OP_STH: begin st = 1'b1; size = lsas_pkg::SIZE_HALF; end
        lsas_pkg::OP_STB: begin st = 1'b1; size = lsas_pkg::SIZE_BYTE; end
        lsas_pkg::OP_LHA: begin
          ok   = !op[0];
          size = lsas_pkg::SIZE_HALF;
          sx   = 1'b1;
          upd  = 1'b0;
        end
        default: ok = 1'b0;
      endcase
    end
    upd = upd && (ra != '0);

    dec.valid_access = ok;
    dec.is_store     = ok && st;
    dec.size_code    = ok ? size : lsas_pkg::SIZE_BYTE;
    dec.sign_extend  = ok && sx;
    dec.eff_address  = ok ? ea : '0;
    dec.data_reg     = ok ? rd : '0;
    dec.update_ra    = ok && upd;
    dec.update_reg   = (ok && upd) ? ra : '0;
    dec.last         = 1'b1;
  end

  always_comb begin
    seq_res.valid_access = 1'b1;
    seq_res.is_store     = seq_is_store;
    seq_res.size_code    = lsas_pkg::SIZE_WORD;
    seq_res.sign_extend  = 1'b0;
    seq_res.eff_address  = seq_address;
    seq_res.data_reg     = seq_reg_index;
    seq_res.update_ra    = 1'b0;
    seq_res.update_reg   = '0;
    seq_res.last         = sts.seq_fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_address   <= '0;
      seq_reg_index <= '0;
      seq_is_store  <= 1'b0;
    end else if (cmd.start_seq) begin
      seq_address   <= ea;
      seq_reg_index <= rd;
      seq_is_store  <= op[0];
    end else if (cmd.emit_seq) begin
      seq_address   <= seq_address + 32'd4;
      seq_reg_index <= seq_reg_index + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_single) begin
      res <= dec;
    end else if (cmd.emit_seq) begin
      res <= seq_res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsas_ctrl.sv =====
// Controller: request acceptance, multiple-word sequence state and result valid.
`default_nettype none
module lsas_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    resp_valid,
  input  wire logic               resp_ready,
  input  wire lsas_pkg::status_t  sts,
  output lsas_pkg::cmd_t          cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEQ  = 1'b1;

  logic state;
  logic state_next;
  logic resp_valid_next;
  logic slot_free;
  logic accept;

  // The result register can take a new value when empty or being drained.
  assign slot_free = !resp_valid || resp_ready;
  assign req_ready = (state == ST_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;

  assign cmd.take_single = accept && !sts.is_multi;
  assign cmd.start_seq   = accept && sts.is_multi;
  assign cmd.emit_seq    = (state == ST_SEQ) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (cmd.start_seq) state_next = ST_SEQ;
      ST_SEQ:  if (cmd.emit_seq && sts.seq_fin) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    resp_valid_next = resp_valid;
    if (cmd.take_single || cmd.emit_seq) begin
      resp_valid_next = 1'b1;
    end else if (resp_ready) begin
      resp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      resp_valid <= 1'b0;
    end else begin
      state      <= state_next;
      resp_valid <= resp_valid_next;
    end
  end

  a_no_req_during_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEQ) |-> !req_ready)
    else $error("request accepted during a multiple-word sequence");

  a_start_enters_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.start_seq |=> (state == ST_SEQ) && !resp_valid)
    else $error("multiple-word start did not enter the sequence state");

  a_fin_leaves_seq: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_seq && sts.seq_fin) |=> (state == ST_IDLE) && resp_valid)
    else $error("final word access did not end the sequence");

  a_one_load_source: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take_single && cmd.emit_seq))
    else $error("result register loaded from two sources");

endmodule
`default_nettype wire

// ===== rtl/load_store_address_sequencer_core.sv =====
// Top level of the load/store address sequencer: controller, datapath and channel wiring.
//
// Each request carries one integer load/store instruction word with the values of its RA and
// RB registers; each result describes one memory access (size, direction, sign extension,
// effective address, data register, optional RA update), or flags an unrecognized
// instruction. Single-access instructions are taken one per cycle while the result side is not
// stalled; the result sits in an output register, so a new request is taken in the cycle the
// previous result is taken. lmw and stmw first load the word sequencer, then produce one word
// access per cycle while the result side is not stalled, from RD up to register 31 with the
// address rising by 4, and the request side is held off until the final access (marked by
// last) has been produced. There is no configuration and no start-up delay after reset.
`default_nettype none
module load_store_address_sequencer_core (
  input  wire logic    clk,
  input  wire logic    rst,
  lsas_req_if.sink     req,
  lsas_resp_if.source  resp
);

  lsas_pkg::cmd_t    cmd;
  lsas_pkg::status_t sts;
  lsas_pkg::result_t res;

  lsas_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .resp_valid (resp.valid),
    .resp_ready (resp.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lsas_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .instr_word (req.instr_word),
    .ra_value   (req.ra_value),
    .rb_value   (req.rb_value),
    .cmd        (cmd),
    .sts        (sts),
    .res        (res)
  );

  assign resp.valid_access = res.valid_access;
  assign resp.is_store     = res.is_store;
  assign resp.size_code    = res.size_code;
  assign resp.sign_extend  = res.sign_extend;
  assign resp.eff_address  = res.eff_address;
  assign resp.data_reg     = res.data_reg;
  assign resp.update_ra    = res.update_ra;
  assign resp.update_reg   = res.update_reg;
  assign resp.last         = res.last;

endmodule
`default_nettype wire
